[design/pts_pkg.sv]
// Shared types and constants for the periodic timer bank.
package pts_pkg;

	localparam int NUM_TIMERS_DEF = 8;
	localparam int IVAL_W         = 31;
	localparam int IDX_W          = 3;
	localparam int MAX_RESULTS    = 8;
	localparam int NF_W           = $clog2(MAX_RESULTS + 1);

	localparam logic [1:0] REQ_START = 2'd0;
	localparam logic [1:0] REQ_STOP  = 2'd1;
	localparam logic [1:0] REQ_TICK  = 2'd2;

	typedef struct packed {
		logic [1:0]        req_type;
		logic [IDX_W-1:0]  timer_index;
		logic [IVAL_W-1:0] interval;
	} req_t;

	typedef struct packed {
		logic             fired;
		logic [IDX_W-1:0] fired_index;
		logic             was_running;
		logic             last;
	} res_t;

	typedef struct packed {
		logic single;
		logic tick_start;
		logic scan;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic scan_done;
	} sts_t;

endpackage

[design/periodic_timer_bank_scheduler.sv]
// Top level of the periodic timer bank: controller plus datapath.
//
//  channel   ports                 handshake
//  request   req (req_t)           accepted when start && !busy
//  result    res (res_t)           one result per res_valid strobe
//
// Start, stop and reserved requests: one result in the cycle after acceptance, busy stays low.
// Tick: busy is high while the timer RAM is swept one
// timer per cycle through its single read port; fired results follow at most one per cycle,
// the final one in the same cycle that busy falls.
// Reset clears all armed bits; the RAM needs no clearing as only armed timers' words are used.
// Results cannot be stalled by the receiver.
module periodic_timer_bank_scheduler #(
	parameter int NUM_TIMERS = pts_pkg::NUM_TIMERS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  pts_pkg::req_t req,
	output logic          res_valid,
	output pts_pkg::res_t res
);

	import pts_pkg::*;

	cmd_t cmd;
	sts_t sts;

	pts_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.req_type(req.req_type),
		.sts     (sts),
		.busy    (busy),
		.cmd     (cmd)
	);

	pts_dp #(
		.NUM_TIMERS(NUM_TIMERS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cmd      (cmd),
		.sts      (sts),
		.res_valid(res_valid),
		.res      (res)
	);

endmodule

[design/pts_ram.sv]
// Generic single write port RAM with registered read.
module pts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[design/pts_ctrl.sv]
// Controller state machine: request decode and tick sweep sequencing.
module pts_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [1:0]    req_type,
	input  pts_pkg::sts_t sts,
	output logic          busy,
	output pts_pkg::cmd_t cmd
);

	import pts_pkg::*;

	typedef enum logic {
		IDLE,
		SCAN
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   accept;

	assign accept = start && !busy_q && (state_q == IDLE);
	assign busy   = busy_q;

	always_comb begin
		cmd            = '0;
		cmd.single     = accept && (req_type != REQ_TICK);
		cmd.tick_start = accept && (req_type == REQ_TICK);
		cmd.scan       = (state_q == SCAN);
		cmd.finish     = (state_q == SCAN) && sts.scan_done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			busy_q  <= 1'b0;
		end else begin
			case (state_q)
				IDLE: begin
					if (accept && (req_type == REQ_TICK)) begin
						state_q <= SCAN;
						busy_q  <= 1'b1;
					end
				end
				SCAN: begin
					if (sts.scan_done) begin
						state_q <= IDLE;
						busy_q  <= 1'b0;
					end
				end
				default: begin
					state_q <= IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		busy_q == (state_q == SCAN))
		else $error("busy out of step with state");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.tick_start |=> (state_q == SCAN))
		else $error("tick did not start sweep");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> (state_q == IDLE) && !busy_q)
		else $error("sweep did not return to idle");

endmodule

[design/pts_dp.sv]
// Datapath: timer RAM, armed bits, tick sweep and result register.
module pts_dp #(
	parameter int NUM_TIMERS = pts_pkg::NUM_TIMERS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  pts_pkg::req_t req,
	input  pts_pkg::cmd_t cmd,
	output pts_pkg::sts_t sts,
	output logic          res_valid,
	output pts_pkg::res_t res
);

	import pts_pkg::*;

	localparam int AW     = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int CW     = $clog2(NUM_TIMERS + 1);
	localparam int WORD_W = 2 * IVAL_W;

	logic [NUM_TIMERS-1:0] armed_q;
	logic [CW-1:0]         cnt_q;
	logic                  proc_s1;
	logic [AW-1:0]         idx_s1;
	logic                  pend_v_q;
	logic [AW-1:0]         pend_idx_q;
	logic [NF_W-1:0]       nfire_q;
	logic                  res_valid_q;
	res_t                  res_q;

	logic              req_ok;
	logic [AW-1:0]     req_a;
	logic              was;
	logic              rd_en;
	logic              we;
	logic [AW-1:0]     waddr;
	logic [WORD_W-1:0] wdata;
	logic [WORD_W-1:0] rdata;
	logic [IVAL_W-1:0] rem;
	logic [IVAL_W-1:0] per;
	logic [IVAL_W-1:0] rem_dec;
	logic              tick_wr;
	logic              hit;
	logic              record;

	assign req_ok  = 32'(req.timer_index) < 32'(NUM_TIMERS);
	assign req_a   = AW'(req.timer_index);
	// reserved requests always report the timer as not running
	assign was     = req_ok && ((req.req_type == REQ_START) || (req.req_type == REQ_STOP))
		&& armed_q[req_a];
	assign rd_en   = cmd.scan && (cnt_q < CW'(NUM_TIMERS));
	assign rem     = rdata[IVAL_W-1:0];
	assign per     = rdata[WORD_W-1:IVAL_W];
	assign rem_dec = (rem != '0) ? rem - IVAL_W'(1) : rem;
	assign tick_wr = proc_s1 && armed_q[idx_s1];
	assign hit     = tick_wr && (rem_dec == '0);
	assign record  = hit && (nfire_q < NF_W'(MAX_RESULTS));

	assign sts.scan_done = (cnt_q == CW'(NUM_TIMERS)) && !proc_s1;
	assign res_valid     = res_valid_q;
	assign res           = res_q;

	always_comb begin
		if (cmd.single && (req.req_type == REQ_START) && req_ok) begin
			we    = 1'b1;
			waddr = req_a;
			wdata = {req.interval, req.interval};
		end else begin
			we    = tick_wr;
			waddr = idx_s1;
			wdata = {per, hit ? per : rem_dec};
		end
	end

	pts_ram #(
		.WIDTH(WORD_W),
		.DEPTH(NUM_TIMERS)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (rd_en),
		.raddr(cnt_q[AW-1:0]),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q     <= '0;
			cnt_q       <= '0;
			proc_s1     <= 1'b0;
			pend_v_q    <= 1'b0;
			nfire_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= cmd.single || (record && pend_v_q) || cmd.finish;
			proc_s1     <= rd_en;
			if (cmd.single && req_ok) begin
				if (req.req_type == REQ_START) begin
					armed_q[req_a] <= (req.interval != '0);
				end else if (req.req_type == REQ_STOP) begin
					armed_q[req_a] <= 1'b0;
				end
			end
			if (cmd.tick_start) begin
				cnt_q    <= '0;
				pend_v_q <= 1'b0;
				nfire_q  <= '0;
			end else if (rd_en) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (record) begin
				pend_v_q <= 1'b1;
				nfire_q  <= nfire_q + NF_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			idx_s1 <= cnt_q[AW-1:0];
		end
		if (record) begin
			pend_idx_q <= idx_s1;
		end
		if (cmd.single) begin
			res_q <= '{fired: 1'b0, fired_index: req.timer_index,
				was_running: was, last: 1'b1};
		end else if (record) begin
			res_q <= '{fired: 1'b1, fired_index: IDX_W'(pend_idx_q),
				was_running: 1'b0, last: 1'b0};
		end else if (cmd.finish) begin
			res_q <= '{fired: pend_v_q,
				fired_index: pend_v_q ? IDX_W'(pend_idx_q) : '0,
				was_running: 1'b0, last: 1'b1};
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> res_valid_q && res_q.last)
		else $error("sweep end without final result");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.single |=> res_valid_q && res_q.last && !res_q.fired)
		else $error("start/stop result malformed");

	assert property (@(posedge clk) disable iff (!arst_n)
		nfire_q <= NF_W'(MAX_RESULTS) && cnt_q <= CW'(NUM_TIMERS))
		else $error("sweep counters out of range");

	assert property (@(posedge clk) disable iff (!arst_n)
		proc_s1 |-> cmd.scan)
		else $error("timer processed outside sweep");

endmodule

[test/periodic_timer_bank_scheduler_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the periodic timer bank: predicted reports vs. result strobes.
module periodic_timer_bank_scheduler_tb;
	import pts_pkg::*;

	localparam logic [1:0] REQ_RESERVED = 2'd3;
	localparam int         NUM_ITEMS    = 480;
	localparam int         CYCLE_LIMIT  = 200000;

	class timer_bank_scoreboard;
		res_t              expected_reports[$];
		logic [IVAL_W-1:0] countdown[NUM_TIMERS_DEF];
		logic [IVAL_W-1:0] reload[NUM_TIMERS_DEF];
		bit                running[NUM_TIMERS_DEF];
		int                failures;

		function new();
			failures = 0;
			for (int t = 0; t < NUM_TIMERS_DEF; t++) begin
				countdown[t] = '0;
				reload[t]    = '0;
				running[t]   = 1'b0;
			end
		endfunction

		function void flag(string msg);
			failures++;
			if (failures <= 10)
				$display("%0t: %s", $realtime, msg);
		endfunction

		function int pending();
			return expected_reports.size();
		endfunction

		function void note_request(req_t r);
			res_t rep;
			res_t fires[$];
			int   idx;
			idx = int'(r.timer_index);
			rep = '0;
			if (r.req_type == REQ_TICK) begin
				for (int t = 0; t < NUM_TIMERS_DEF; t++) begin
					if (running[t]) begin
						if (countdown[t] != '0)
							countdown[t] = countdown[t] - IVAL_W'(1);
						if (countdown[t] == '0) begin
							countdown[t]    = reload[t];
							rep             = '0;
							rep.fired       = 1'b1;
							rep.fired_index = IDX_W'(t);
							fires.push_back(rep);
						end
					end
				end
				if (fires.size() == 0) begin
					rep      = '0;
					rep.last = 1'b1;
					expected_reports.push_back(rep);
				end else begin
					foreach (fires[k]) begin
						rep      = fires[k];
						rep.last = (k == fires.size() - 1);
						expected_reports.push_back(rep);
					end
				end
			end else begin
				rep.fired_index = r.timer_index;
				rep.last        = 1'b1;
				if (idx < NUM_TIMERS_DEF && r.req_type == REQ_START) begin
					rep.was_running = running[idx];
					reload[idx]     = r.interval;
					countdown[idx]  = r.interval;
					running[idx]    = (r.interval != '0);
				end else if (idx < NUM_TIMERS_DEF && r.req_type == REQ_STOP) begin
					rep.was_running = running[idx];
					if (running[idx]) begin
						running[idx]   = 1'b0;
						countdown[idx] = '0;
						reload[idx]    = '0;
					end
				end
				expected_reports.push_back(rep);
			end
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (expected_reports.size() == 0) begin
				flag($sformatf("unexpected result fired=%0b idx=%0d was=%0b last=%0b",
					got.fired, got.fired_index, got.was_running, got.last));
				return;
			end
			want = expected_reports.pop_front();
			if (got.fired !== want.fired || got.fired_index !== want.fired_index ||
			    got.was_running !== want.was_running || got.last !== want.last)
				flag($sformatf({"mismatch: expected fired=%0b idx=%0d was=%0b last=%0b, ",
					"got fired=%0b idx=%0d was=%0b last=%0b"},
					want.fired, want.fired_index, want.was_running, want.last,
					got.fired, got.fired_index, got.was_running, got.last));
		endfunction

		function void count_leftovers();
			while (expected_reports.size() != 0) begin
				void'(expected_reports.pop_front());
				flag("expected result never arrived");
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	req_t req;
	logic res_valid;
	res_t res;
	int   cycles = 0;
	bit   burst;

	timer_bank_scoreboard sb;

	periodic_timer_bank_scheduler dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.res_valid (res_valid),
		.res       (res)
	);

	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				sb.note_request(req);
			if (res_valid)
				sb.check_result(res);
		end
	end

	function automatic req_t make_request(logic [1:0] kind, int idx, logic [IVAL_W-1:0] ival);
		req_t r;
		r.req_type    = kind;
		r.timer_index = IDX_W'(idx);
		r.interval    = ival;
		return r;
	endfunction

	function automatic req_t random_request();
		req_t r;
		int   pick;
		pick          = $urandom_range(0, 99);
		r.timer_index = IDX_W'($urandom_range(0, 7));
		r.interval    = IVAL_W'($urandom);
		if (pick < 50)
			r.req_type = REQ_TICK;
		else if (pick < 75) begin
			r.req_type = REQ_START;
			r.interval = IVAL_W'($urandom_range(1, 6));
		end else if (pick < 80)
			r.req_type = REQ_START;
		else if (pick < 82) begin
			r.req_type = REQ_START;
			r.interval = '0;
		end else if (pick < 95)
			r.req_type = REQ_STOP;
		else
			r.req_type = REQ_RESERVED;
		return r;
	endfunction

	// called on a rising edge; returns on the edge that takes the request
	task automatic send_request(req_t r);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req   <= r;
		do @(posedge clk); while (busy);
	endtask

	task automatic wait_until_quiet();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	initial begin
		sb     = new();
		arst_n = 1'b0;
		start  = 1'b0;
		req    = '0;
		burst  = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(make_request(REQ_RESERVED, 7, 31'h7fffffff));
		send_request(make_request(REQ_TICK, 5, 31'h2aaaaaaa));
		for (int t = 0; t < NUM_TIMERS_DEF; t++)
			send_request(make_request(REQ_START, t, 31'd1));
		send_request(make_request(REQ_TICK, 0, '0));
		send_request(make_request(REQ_START, 2, 31'd2));
		send_request(make_request(REQ_STOP, 3, '0));
		send_request(make_request(REQ_STOP, 3, 31'h7fffffff));
		send_request(make_request(REQ_START, 5, '0));
		send_request(make_request(REQ_TICK, 7, '0));
		send_request(make_request(REQ_TICK, 2, '0));
		send_request(make_request(REQ_START, 6, 31'h7fffffff));
		send_request(make_request(REQ_START, 1, 31'h55555555));
		send_request(make_request(REQ_START, 0, '0));
		send_request(make_request(REQ_STOP, 2, '0));
		send_request(make_request(REQ_STOP, 4, '0));
		send_request(make_request(REQ_STOP, 7, '0));
		// only long-period timers left: empty tick
		send_request(make_request(REQ_TICK, 0, '0));
		send_request(make_request(REQ_RESERVED, 0, '0));
		wait_until_quiet();

		for (int n = 0; n < NUM_ITEMS; n++) begin
			if (n % 40 == 0)
				burst = ($urandom_range(0, 2) == 0);
			send_request(random_request());
			if (n % 120 == 119)
				wait_until_quiet();
		end

		wait_until_quiet();
		repeat (NUM_TIMERS_DEF + 8) @(posedge clk);
		sb.count_leftovers();
		if (sb.failures == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
